[rtl/asa_pkg.sv]
// Shared types and constants for the arrive steering acceleration unit.
// Depends on nothing; every other file imports it.
package asa_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned CfgW        = 31;
  localparam int unsigned DiffW       = 33;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned WideW       = 128;
  localparam int unsigned HalfW       = 64;
  localparam int unsigned FracW       = 16;
  localparam int unsigned SettleReset = 65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_X        = 4'd0,
    CFG_TARGET_Y        = 4'd1,
    CFG_TARGET_Z        = 4'd2,
    CFG_ARRIVAL_RADIUS  = 4'd3,
    CFG_SLOWDOWN_RADIUS = 4'd4,
    CFG_TOP_SPEED       = 4'd5,
    CFG_TOP_ACCEL       = 4'd6,
    CFG_SETTLE_TIME     = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } alu_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WAIT, ST_DSQ, ST_DSQ_ACC, ST_DSQRT, ST_CHECK, ST_SPD, ST_SPD_CAP,
    ST_DES, ST_DESD, ST_DESC, ST_LIN, ST_LINC, ST_MSQ, ST_MSQ_ACC, ST_MSQRT,
    ST_CLAMP, ST_CLM, ST_CLD, ST_CLC, ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic signed [DataW-1:0] target_x;
    logic signed [DataW-1:0] target_y;
    logic signed [DataW-1:0] target_z;
    logic [CfgW-1:0]         arrival_radius;
    logic [CfgW-1:0]         slowdown_radius;
    logic [CfgW-1:0]         top_speed;
    logic [CfgW-1:0]         top_accel;
    logic [CfgW-1:0]         settle_time;
  } cfg_t;

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dz;
    logic signed [DataW-1:0] vx;
    logic signed [DataW-1:0] vy;
    logic signed [DataW-1:0] vz;
  } item_t;

  typedef struct packed {
    logic push;
  } q_ctl_t;

endpackage

[rtl/asa_front.sv]
// Front end: configuration registers, input acceptance and offset to target.
// Depends on asa_pkg.
module asa_front import asa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [DataW-1:0] pos_x_i,
  input  logic signed [DataW-1:0] pos_y_i,
  input  logic signed [DataW-1:0] pos_z_i,
  input  logic signed [DataW-1:0] vel_x_i,
  input  logic signed [DataW-1:0] vel_y_i,
  input  logic signed [DataW-1:0] vel_z_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [DataW-1:0]        cfg_data_i,
  input  logic                    full_i,
  output q_ctl_t                  q_ctl_o,
  output item_t                   item_o,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign busy        = full_i;
  assign q_ctl_o.push = start & ~full_i;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_X:        cfg_d.target_x        = cfg_data_i;
        CFG_TARGET_Y:        cfg_d.target_y        = cfg_data_i;
        CFG_TARGET_Z:        cfg_d.target_z        = cfg_data_i;
        CFG_ARRIVAL_RADIUS:  cfg_d.arrival_radius  = cfg_data_i[CfgW-1:0];
        CFG_SLOWDOWN_RADIUS: cfg_d.slowdown_radius = cfg_data_i[CfgW-1:0];
        CFG_TOP_SPEED:       cfg_d.top_speed       = cfg_data_i[CfgW-1:0];
        CFG_TOP_ACCEL:       cfg_d.top_accel       = cfg_data_i[CfgW-1:0];
        CFG_SETTLE_TIME:     cfg_d.settle_time     = cfg_data_i[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q             <= '0;
      cfg_q.settle_time <= CfgW'(SettleReset);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    item_o.dx = DiffW'(cfg_q.target_x) - DiffW'(pos_x_i);
    item_o.dy = DiffW'(cfg_q.target_y) - DiffW'(pos_y_i);
    item_o.dz = DiffW'(cfg_q.target_z) - DiffW'(pos_z_i);
    item_o.vx = vel_x_i;
    item_o.vy = vel_y_i;
    item_o.vz = vel_z_i;
  end

endmodule

[rtl/asa_queue.sv]
// Short item queue between the front end and the sequencer.
// Depends on asa_pkg.
module asa_queue import asa_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  q_ctl_t q_ctl_i,
  input  item_t  item_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output item_t  item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (q_ctl_i.push) wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    if (do_pop)       rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    if (q_ctl_i.push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (!q_ctl_i.push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_ctl_i.push) mem_q[wr_q] <= item_i;
  end

endmodule

[rtl/asa_alu.sv]
// Bit-serial multiply, restoring divide and square root unit.
// Depends on asa_pkg.
module asa_alu import asa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  alu_op_e          op_i,
  input  logic [WideW-1:0] opa_i,
  input  logic [HalfW-1:0] opb_i,
  output logic             done_o,
  output logic [WideW-1:0] res_o
);

  localparam int unsigned CntW = $clog2(WideW + 1);
  localparam int unsigned RemW = HalfW + 4;

  logic             run_q, run_d, done_q, done_d;
  alu_op_e          op_q, op_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WideW-1:0] src_q, src_d, acc_q, acc_d;
  logic [HalfW-1:0] b_q, b_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [WideW-1:0] mul_sum;
  logic [HalfW:0]   div_rem, div_diff;
  logic [RemW-1:0]  sq_rem, sq_trial, sq_diff;

  assign done_o = done_q;
  assign res_o  = acc_q;

  always_comb begin
    mul_sum  = {acc_q[WideW-2:0], 1'b0}
             + (b_q[HalfW-1] ? WideW'(src_q[HalfW-1:0]) : '0);
    div_rem  = {rem_q[HalfW-1:0], src_q[WideW-1]};
    div_diff = div_rem - {1'b0, b_q};
    sq_rem   = {rem_q[RemW-3:0], src_q[WideW-1 -: 2]};
    sq_trial = {acc_q[RemW-3:0], 2'b01};
    sq_diff  = sq_rem - sq_trial;

    run_d  = run_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    src_d  = src_q;
    acc_d  = acc_q;
    b_d    = b_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      op_d  = op_i;
      src_d = opa_i;
      b_d   = opb_i;
      acc_d = '0;
      rem_d = '0;
      cnt_d = (op_i == OP_DIV) ? CntW'(WideW) : CntW'(HalfW);
    end else if (run_q) begin
      case (op_q)
        OP_MUL: begin
          acc_d = mul_sum;
          b_d   = {b_q[HalfW-2:0], 1'b0};
        end
        OP_DIV: begin
          src_d = {src_q[WideW-2:0], 1'b0};
          if (div_rem >= {1'b0, b_q}) begin
            rem_d = RemW'(div_diff[HalfW-1:0]);
            acc_d = {acc_q[WideW-2:0], 1'b1};
          end else begin
            rem_d = RemW'(div_rem[HalfW-1:0]);
            acc_d = {acc_q[WideW-2:0], 1'b0};
          end
        end
        OP_SQRT: begin
          src_d = {src_q[WideW-3:0], 2'b00};
          if (sq_rem >= sq_trial) begin
            rem_d = sq_diff;
            acc_d = {acc_q[WideW-2:0], 1'b1};
          end else begin
            rem_d = sq_rem;
            acc_d = {acc_q[WideW-2:0], 1'b0};
          end
        end
        default: ;
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    acc_q <= acc_d;
    b_q   <= b_d;
    rem_q <= rem_d;
  end

endmodule

[rtl/asa_back.sv]
// Back end: sequencer that runs the arrive steering math on the shared unit.
// Depends on asa_pkg and asa_alu.
module asa_back import asa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    item_valid_i,
  input  item_t                   item_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic                    has_steering_o,
  output logic signed [DataW-1:0] accel_x_o,
  output logic signed [DataW-1:0] accel_y_o,
  output logic signed [DataW-1:0] accel_z_o
);

  localparam logic [1:0] LastAxis = 2'd2;
  localparam int unsigned DiffMagW = HalfW + 2;
  localparam logic signed [HalfW-1:0] SatHi = HalfW'(64'sd2147483647);
  localparam logic signed [HalfW-1:0] SatLo = -HalfW'(64'sd2147483648);

  seq_state_e state_q, state_d, ret_q, ret_d;
  logic [1:0] k_q, k_d;
  logic [DiffW-1:0] dmag_q [3];
  logic [DiffW-1:0] dmag_d [3];
  logic [2:0] dneg_q, dneg_d;
  logic signed [DataW-1:0] vel_q [3];
  logic signed [DataW-1:0] vel_d [3];
  logic [WideW-1:0] sum_q, sum_d;
  logic [HalfW-1:0] dist_q, dist_d, speed_q, speed_d, m_q, m_d;
  logic signed [HalfW-1:0] want_q, want_d;
  logic signed [HalfW-1:0] lin_q [3];
  logic signed [HalfW-1:0] lin_d [3];
  logic lneg_q, lneg_d;
  logic done_q, done_d, has_q, has_d;
  logic signed [DataW-1:0] out_q [3];
  logic signed [DataW-1:0] out_d [3];

  logic alu_start, alu_done;
  alu_op_e alu_op;
  logic [WideW-1:0] alu_a, alu_res;
  logic [HalfW-1:0] alu_b, res_lo, lin_mag, settle;
  logic signed [HalfW-1:0] quo;
  logic signed [DiffMagW-1:0] diff;
  logic [DiffMagW-1:0] diff_mag;
  logic [HalfW-1:0] arrival, slow, top, accel;
  logic [1:0] k_next;

  asa_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .op_i    (alu_op),
    .opa_i   (alu_a),
    .opb_i   (alu_b),
    .done_o  (alu_done),
    .res_o   (alu_res)
  );

  assign done_o         = done_q;
  assign has_steering_o = has_q;
  assign accel_x_o      = out_q[0];
  assign accel_y_o      = out_q[1];
  assign accel_z_o      = out_q[2];

  always_comb begin
    res_lo   = alu_res[HalfW-1:0];
    quo      = signed'(res_lo);
    lin_mag  = lin_q[k_q][HalfW-1] ? HalfW'(-lin_q[k_q]) : HalfW'(lin_q[k_q]);
    diff     = DiffMagW'(want_q) - DiffMagW'(vel_q[k_q]);
    diff_mag = diff[DiffMagW-1] ? DiffMagW'(-diff) : DiffMagW'(diff);
    arrival  = HalfW'(cfg_i.arrival_radius);
    slow     = HalfW'(cfg_i.slowdown_radius);
    top      = HalfW'(cfg_i.top_speed);
    accel    = HalfW'(cfg_i.top_accel);
    settle   = (cfg_i.settle_time == '0) ? HalfW'(1) : HalfW'(cfg_i.settle_time);
    k_next   = (k_q == LastAxis) ? 2'd0 : k_q + 1'b1;
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      ST_IDLE:    if (item_valid_i) state_d = ST_DSQ;
      ST_WAIT:    if (alu_done) state_d = ret_q;
      ST_DSQ:     begin state_d = ST_WAIT; ret_d = ST_DSQ_ACC; end
      ST_DSQ_ACC: state_d = (k_q == LastAxis) ? ST_DSQRT : ST_DSQ;
      ST_DSQRT:   begin state_d = ST_WAIT; ret_d = ST_CHECK; end
      ST_CHECK: begin
        if (res_lo < arrival) state_d = ST_IDLE;
        else if (res_lo > slow || slow == '0) state_d = ST_DES;
        else begin
          state_d = ST_WAIT;
          ret_d   = ST_SPD;
        end
      end
      ST_SPD:     begin state_d = ST_WAIT; ret_d = ST_SPD_CAP; end
      ST_SPD_CAP: state_d = ST_DES;
      ST_DES: begin
        if (dist_q == '0) state_d = ST_LIN;
        else begin
          state_d = ST_WAIT;
          ret_d   = ST_DESD;
        end
      end
      ST_DESD:    begin state_d = ST_WAIT; ret_d = ST_DESC; end
      ST_DESC:    state_d = ST_LIN;
      ST_LIN:     begin state_d = ST_WAIT; ret_d = ST_LINC; end
      ST_LINC:    state_d = (k_q == LastAxis) ? ST_MSQ : ST_DES;
      ST_MSQ:     begin state_d = ST_WAIT; ret_d = ST_MSQ_ACC; end
      ST_MSQ_ACC: state_d = (k_q == LastAxis) ? ST_MSQRT : ST_MSQ;
      ST_MSQRT:   begin state_d = ST_WAIT; ret_d = ST_CLAMP; end
      ST_CLAMP:   state_d = (res_lo > accel) ? ST_CLM : ST_OUT;
      ST_CLM:     begin state_d = ST_WAIT; ret_d = ST_CLD; end
      ST_CLD:     begin state_d = ST_WAIT; ret_d = ST_CLC; end
      ST_CLC:     state_d = (k_q == LastAxis) ? ST_OUT : ST_CLM;
      ST_OUT:     state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    alu_start = 1'b0;
    alu_op    = OP_MUL;
    alu_a     = '0;
    alu_b     = '0;
    k_d       = k_q;
    dmag_d    = dmag_q;
    dneg_d    = dneg_q;
    vel_d     = vel_q;
    sum_d     = sum_q;
    dist_d    = dist_q;
    speed_d   = speed_q;
    m_d       = m_q;
    want_d    = want_q;
    lin_d     = lin_q;
    lneg_d    = lneg_q;
    done_d    = 1'b0;
    has_d     = has_q;
    out_d     = out_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          pop_o     = 1'b1;
          dneg_d    = {item_i.dz[DiffW-1], item_i.dy[DiffW-1], item_i.dx[DiffW-1]};
          dmag_d[0] = item_i.dx[DiffW-1] ? DiffW'(-item_i.dx) : DiffW'(item_i.dx);
          dmag_d[1] = item_i.dy[DiffW-1] ? DiffW'(-item_i.dy) : DiffW'(item_i.dy);
          dmag_d[2] = item_i.dz[DiffW-1] ? DiffW'(-item_i.dz) : DiffW'(item_i.dz);
          vel_d[0]  = item_i.vx;
          vel_d[1]  = item_i.vy;
          vel_d[2]  = item_i.vz;
          sum_d     = '0;
          k_d       = 2'd0;
        end
      end
      ST_DSQ: begin
        alu_start = 1'b1;
        alu_a     = WideW'(dmag_q[k_q]);
        alu_b     = HalfW'(dmag_q[k_q]);
      end
      ST_DSQ_ACC: begin
        sum_d = sum_q + alu_res;
        k_d   = k_next;
      end
      ST_DSQRT: begin
        alu_start = 1'b1;
        alu_op    = OP_SQRT;
        alu_a     = sum_q;
      end
      ST_CHECK: begin
        dist_d = res_lo;
        if (res_lo < arrival) begin
          done_d = 1'b1;
          has_d  = 1'b0;
          out_d  = '{default: '0};
        end else if (res_lo > slow) begin
          speed_d = top;
        end else if (slow == '0) begin
          speed_d = '0;
        end else begin
          alu_start = 1'b1;
          alu_a     = WideW'(top);
          alu_b     = res_lo;
        end
      end
      ST_SPD: begin
        alu_start = 1'b1;
        alu_op    = OP_DIV;
        alu_a     = alu_res;
        alu_b     = slow;
      end
      ST_SPD_CAP: speed_d = res_lo;
      ST_DES: begin
        if (dist_q == '0) want_d = '0;
        else begin
          alu_start = 1'b1;
          alu_a     = WideW'(dmag_q[k_q]);
          alu_b     = speed_q;
        end
      end
      ST_DESD: begin
        alu_start = 1'b1;
        alu_op    = OP_DIV;
        alu_a     = alu_res;
        alu_b     = dist_q;
      end
      ST_DESC: want_d = dneg_q[k_q] ? -quo : quo;
      ST_LIN: begin
        lneg_d    = diff[DiffMagW-1];
        alu_start = 1'b1;
        alu_op    = OP_DIV;
        alu_a     = WideW'({diff_mag, {FracW{1'b0}}});
        alu_b     = settle;
      end
      ST_LINC: begin
        lin_d[k_q] = lneg_q ? -quo : quo;
        k_d        = k_next;
        if (k_q == LastAxis) sum_d = '0;
      end
      ST_MSQ: begin
        alu_start = 1'b1;
        alu_a     = WideW'(lin_mag);
        alu_b     = lin_mag;
      end
      ST_MSQ_ACC: begin
        sum_d = sum_q + alu_res;
        k_d   = k_next;
      end
      ST_MSQRT: begin
        alu_start = 1'b1;
        alu_op    = OP_SQRT;
        alu_a     = sum_q;
      end
      ST_CLAMP: m_d = res_lo;
      ST_CLM: begin
        lneg_d    = lin_q[k_q][HalfW-1];
        alu_start = 1'b1;
        alu_a     = WideW'(lin_mag);
        alu_b     = accel;
      end
      ST_CLD: begin
        alu_start = 1'b1;
        alu_op    = OP_DIV;
        alu_a     = alu_res;
        alu_b     = m_q;
      end
      ST_CLC: begin
        lin_d[k_q] = lneg_q ? -quo : quo;
        k_d        = k_next;
      end
      ST_OUT: begin
        done_d = 1'b1;
        has_d  = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (lin_q[i] > SatHi)      out_d[i] = SatHi[DataW-1:0];
          else if (lin_q[i] < SatLo) out_d[i] = SatLo[DataW-1:0];
          else                       out_d[i] = lin_q[i][DataW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      k_q     <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      k_q     <= k_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dmag_q  <= dmag_d;
    dneg_q  <= dneg_d;
    vel_q   <= vel_d;
    sum_q   <= sum_d;
    dist_q  <= dist_d;
    speed_q <= speed_d;
    m_q     <= m_d;
    want_q  <= want_d;
    lin_q   <= lin_d;
    lneg_q  <= lneg_d;
    has_q   <= has_d;
    out_q   <= out_d;
  end

endmodule

[rtl/arrive_steering_accel_unit.sv]
// Arrive steering unit: an item is taken and queued (Depth deep); the sequencer
// then works on one item at a time on the shared bit-serial unit, which runs one
// multiply, divide or root at a time; an item inside the arrival radius ends early.
// Items are accepted back to back while the queue has room (busy when full).
// Result strobe done_o lasts one cycle; the receiver cannot stall it.
// Reset (rst_ni low, asynchronous) empties the queue and loads register defaults.
module arrive_steering_accel_unit import asa_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [DataW-1:0] pos_x_i,
  input  logic signed [DataW-1:0] pos_y_i,
  input  logic signed [DataW-1:0] pos_z_i,
  input  logic signed [DataW-1:0] vel_x_i,
  input  logic signed [DataW-1:0] vel_y_i,
  input  logic signed [DataW-1:0] vel_z_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [DataW-1:0]        cfg_data_i,
  output logic                    done_o,
  output logic                    has_steering_o,
  output logic signed [DataW-1:0] accel_x_o,
  output logic signed [DataW-1:0] accel_y_o,
  output logic signed [DataW-1:0] accel_z_o
);

  q_ctl_t q_ctl;
  item_t  front_item, back_item;
  cfg_t   cfg;
  logic   q_full, q_valid, q_pop;

  asa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .vel_z_i     (vel_z_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .full_i      (q_full),
    .q_ctl_o     (q_ctl),
    .item_o      (front_item),
    .cfg_o       (cfg)
  );

  asa_queue #(.Depth(Depth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_ctl_i (q_ctl),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (back_item)
  );

  asa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .item_valid_i   (q_valid),
    .item_i         (back_item),
    .pop_o          (q_pop),
    .done_o         (done_o),
    .has_steering_o (has_steering_o),
    .accel_x_o      (accel_x_o),
    .accel_y_o      (accel_y_o),
    .accel_z_o      (accel_z_o)
  );

endmodule

[rtl/asa_checker.sv]
// Port-level checks for the arrive steering unit, bound to the top level.
// Depends on asa_pkg and arrive_steering_accel_unit.
module asa_checker import asa_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    cfg_ready_o,
  input logic                    done_o,
  input logic                    has_steering_o,
  input logic signed [DataW-1:0] accel_x_o,
  input logic signed [DataW-1:0] accel_y_o,
  input logic signed [DataW-1:0] accel_z_o
);

  a_no_steer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !has_steering_o |-> accel_x_o == '0 && accel_y_o == '0 && accel_z_o == '0)
    else $error("no-steering result carries nonzero acceleration");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind arrive_steering_accel_unit asa_checker u_asa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cfg_ready_o    (cfg_ready_o),
  .done_o         (done_o),
  .has_steering_o (has_steering_o),
  .accel_x_o      (accel_x_o),
  .accel_y_o      (accel_y_o),
  .accel_z_o      (accel_z_o)
);

[tb/sv/tb_top.sv]
// Self-checking bench for the arrive steering acceleration unit.
// Depends on asa_pkg and arrive_steering_accel_unit; predicts every result in place.
`timescale 1ns / 1ps
module tb_top;
  import asa_pkg::*;

  typedef struct {
    logic signed [DataW-1:0] px, py, pz, vx, vy, vz;
  } agent_t;

  typedef struct {
    logic                    steer;
    logic signed [DataW-1:0] ax, ay, az;
  } steer_t;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 4'(CFG_SETTLE_TIME) + 4'd1;
  localparam logic [CfgW-1:0]    CfgMax      = {CfgW{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [DataW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [DataW-1:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [DataW-1:0] cfg_data = '0;
  logic done;
  logic has_steering;
  logic signed [DataW-1:0] accel_x, accel_y, accel_z;

  agent_t agent_q[$];
  steer_t steer_q[$];
  agent_t cur_agent;
  bit     moved;
  int     idle_pct = 0;
  int     errors = 0;

  longint          tgt[3];
  logic [CfgW-1:0] arrival_r, slowdown_r, speed_r, accel_r, settle_r;

  arrive_steering_accel_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .vel_x_i        (vel_x),
    .vel_y_i        (vel_y),
    .vel_z_i        (vel_z),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .done_o         (done),
    .has_steering_o (has_steering),
    .accel_x_o      (accel_x),
    .accel_y_o      (accel_y),
    .accel_z_o      (accel_z)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [WideW-1:0] mag_of(longint v);
    return (v < 0) ? WideW'(-v) : WideW'(v);
  endfunction

  function automatic logic [WideW-1:0] root_floor(logic [WideW-1:0] v);
    logic [WideW-1:0] r, t;
    r = '0;
    for (int b = HalfW - 1; b >= 0; b--) begin
      t = r | (WideW'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint scale_trunc(longint v, logic [WideW-1:0] num,
                                         logic [WideW-1:0] den);
    logic [WideW-1:0] q;
    q = (mag_of(v) * num) / den;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [DataW-1:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return DataW'(v);
  endfunction

  function automatic steer_t steer_predict(agent_t a);
    steer_t r;
    longint d[3], vel[3], lin[3], want;
    logic [WideW-1:0] dist_v, speed, settle, m, sq;
    vel = '{longint'(a.vx), longint'(a.vy), longint'(a.vz)};
    d[0] = tgt[0] - longint'(a.px);
    d[1] = tgt[1] - longint'(a.py);
    d[2] = tgt[2] - longint'(a.pz);
    sq = '0;
    for (int i = 0; i < 3; i++) sq += mag_of(d[i]) * mag_of(d[i]);
    dist_v = root_floor(sq);
    r = '{1'b0, '0, '0, '0};
    if (dist_v < WideW'(arrival_r)) return r;
    if (dist_v > WideW'(slowdown_r)) speed = WideW'(speed_r);
    else if (slowdown_r == '0) speed = '0;
    else speed = (WideW'(speed_r) * dist_v) / WideW'(slowdown_r);
    settle = (settle_r == '0) ? WideW'(1) : WideW'(settle_r);
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      want = (dist_v != '0) ? scale_trunc(d[i], speed, dist_v) : 0;
      lin[i] = scale_trunc(want - vel[i], WideW'(65536), settle);
      sq += mag_of(lin[i]) * mag_of(lin[i]);
    end
    m = root_floor(sq);
    if (m > WideW'(accel_r))
      for (int i = 0; i < 3; i++) lin[i] = scale_trunc(lin[i], WideW'(accel_r), m);
    r.steer = 1'b1;
    r.ax = sat32(lin[0]);
    r.ay = sat32(lin[1]);
    r.az = sat32(lin[2]);
    return r;
  endfunction

  // driver: hold the item until the transfer, then advance or idle
  always @(negedge clk_i) begin
    if (!start || moved) begin
      moved = 1'b0;
      if (agent_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur_agent = agent_q.pop_front();
        start <= 1'b1;
        pos_x <= cur_agent.px;
        pos_y <= cur_agent.py;
        pos_z <= cur_agent.pz;
        vel_x <= cur_agent.vx;
        vel_y <= cur_agent.vy;
        vel_z <= cur_agent.vz;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: record accepted items and check each result strobe
  always @(posedge clk_i) begin
    steer_t exp_r;
    if (rst_ni) begin
      if (done) begin
        if (steer_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          exp_r = steer_q.pop_front();
          if (has_steering !== exp_r.steer) begin
            $error("has_steering exp %0d got %0d", exp_r.steer, has_steering);
            errors++;
          end
          if (accel_x !== exp_r.ax) begin
            $error("accel_x exp %0d got %0d", exp_r.ax, accel_x);
            errors++;
          end
          if (accel_y !== exp_r.ay) begin
            $error("accel_y exp %0d got %0d", exp_r.ay, accel_y);
            errors++;
          end
          if (accel_z !== exp_r.az) begin
            $error("accel_z exp %0d got %0d", exp_r.az, accel_z);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        steer_q.push_back(steer_predict(cur_agent));
        moved = 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      CFG_TARGET_X:        tgt[0] = longint'($signed(val));
      CFG_TARGET_Y:        tgt[1] = longint'($signed(val));
      CFG_TARGET_Z:        tgt[2] = longint'($signed(val));
      CFG_ARRIVAL_RADIUS:  arrival_r = val[CfgW-1:0];
      CFG_SLOWDOWN_RADIUS: slowdown_r = val[CfgW-1:0];
      CFG_TOP_SPEED:       speed_r = val[CfgW-1:0];
      CFG_TOP_ACCEL:       accel_r = val[CfgW-1:0];
      CFG_SETTLE_TIME:     settle_r = val[CfgW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [DataW-1:0] tx, ty, tz, arr, slow, spd, acc, st);
    write_reg(CFG_TARGET_X, tx);
    write_reg(CFG_TARGET_Y, ty);
    write_reg(CFG_TARGET_Z, tz);
    write_reg(CFG_ARRIVAL_RADIUS, arr);
    write_reg(CFG_SLOWDOWN_RADIUS, slow);
    write_reg(CFG_TOP_SPEED, spd);
    write_reg(CFG_TOP_ACCEL, acc);
    write_reg(CFG_SETTLE_TIME, st);
    write_reg(CfgIdxSpare + 4'($urandom_range(7)), $urandom);
  endtask

  task automatic drain();
    while (agent_q.size() != 0 || start || steer_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] near(longint c);
    return DataW'(c + longint'($signed($urandom) >>> $urandom_range(31, 1)));
  endfunction

  function automatic agent_t rand_agent();
    agent_t a;
    if ($urandom_range(3) == 0) begin
      a = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      a.px = near(tgt[0]);
      a.py = near(tgt[1]);
      a.pz = near(tgt[2]);
      a.vx = $signed($urandom) >>> $urandom_range(31, 0);
      a.vy = $signed($urandom) >>> $urandom_range(31, 0);
      a.vz = $signed($urandom) >>> $urandom_range(31, 0);
    end
    return a;
  endfunction

  function automatic logic [DataW-1:0] r31(int unsigned hi);
    return {1'($urandom_range(1)), 31'($urandom_range(hi))};
  endfunction

  task automatic set_phase(int k);
    case (k % 4)
      0: write_all($urandom, $urandom, $urandom, r31(1 << 18), r31(1 << 24),
                   r31(1 << 21), r31(1 << 19), r31(1 << 18) | 32'd1);
      1: write_all(32'h7fffffff, 32'h80000000, $urandom, 32'h80000000,
                   {1'b1, CfgMax}, {1'b0, CfgMax}, {1'b1, CfgMax}, 32'h80000000);
      2: write_all(32'h80000000, 32'h7fffffff, '0, {1'b0, CfgMax}, '0, '0, '0,
                   {1'b1, CfgMax});
      default: write_all($urandom, $urandom, $urandom, r31(1 << 20), r31(1 << 16),
                         $urandom, $urandom, r31(1 << 12));
    endcase
  endtask

  initial begin
    longint ax;
    tgt = '{0, 0, 0};
    arrival_r = '0;
    slowdown_r = '0;
    speed_r = '0;
    accel_r = '0;
    settle_r = CfgW'(SettleReset);
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    agent_q.push_back('{0, 0, 0, 0, 0, 0});
    agent_q.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    agent_q.push_back('{32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000000});
    agent_q.push_back('{32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 5});
    drain();

    write_all(32'h0010_0000, 32'hfff0_0000, 32'h0003_0000, 32'h0001_0000,
              32'h0008_0000, 32'h0004_0000, 32'h0002_0000, 32'h0000_8000);
    ax = tgt[0];
    agent_q.push_back('{DataW'(ax), DataW'(tgt[1]), DataW'(tgt[2]), 0, 0, 0});
    agent_q.push_back('{DataW'(ax - 32768), DataW'(tgt[1]), DataW'(tgt[2]), 7, -7, 0});
    agent_q.push_back('{DataW'(ax - 65536), DataW'(tgt[1]), DataW'(tgt[2]), 0, 0, 0});
    agent_q.push_back('{DataW'(ax + 32'h0008_0000), DataW'(tgt[1]), DataW'(tgt[2]),
                        0, 65536, 0});
    agent_q.push_back('{DataW'(ax - 32'h0064_0000), DataW'(tgt[1]), DataW'(tgt[2]),
                        0, 0, -65536});
    agent_q.push_back('{DataW'(ax), DataW'(tgt[1] + 32'h0002_0000), DataW'(tgt[2]),
                        32'h7fffffff, 32'h80000000, 32'h7fffffff});
    agent_q.push_back('{32'h80000000, 32'h7fffffff, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000000});
    agent_q.push_back('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0});
    drain();

    write_all(0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
    agent_q.push_back('{0, 0, 0, 1, 2, 3});
    agent_q.push_back('{0, 0, 0, 32'h7fffffff, 0, 32'h80000000});
    agent_q.push_back('{1, 0, 0, 0, 0, 0});
    drain();

    for (int p = 0; p < 6; p++) begin
      idle_pct = (p < 2) ? 22 : (p < 4) ? 57 : 0;
      set_phase(p);
      repeat (200) agent_q.push_back(rand_agent());
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[arrive_steering_accel_unit.f]
rtl/asa_pkg.sv
rtl/asa_front.sv
rtl/asa_queue.sv
rtl/asa_alu.sv
rtl/asa_back.sv
rtl/arrive_steering_accel_unit.sv
rtl/asa_checker.sv
tb/sv/tb_top.sv
